// ===== hw/rtl/itoa_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam logic [7:0]  CHAR_ZERO      = 8'd48;
  localparam logic [7:0]  CHAR_MINUS     = 8'd45;
  localparam logic [3:0]  BCD_LIMIT      = 4'd5;
  localparam logic [3:0]  BCD_ADJUST     = 4'd3;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic sign;
    logic digit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic cnt_one;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/itoa_ctrl.sv =====
// Controller state machine: sequences load, conversion, zero skip and character output.
module itoa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t cmd
);
  import itoa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_zero && !sts.cnt_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.sign  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.digit = 1'b1;
          if (sts.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/itoa_dp.sv =====
// Datapath: magnitude, shift-and-add-3 BCD converter, digit shifter and output register.
module itoa_dp #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  itoa_pkg::cmd_t        cmd,
  output itoa_pkg::sts_t        sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [7:0]            out_char,
  output logic                  out_last
);
  import itoa_pkg::*;

  localparam int unsigned ND     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W  = ND * 4;
  localparam int unsigned BCNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned DCNT_W = $clog2(ND + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic                  neg_r, neg_nxt;
  logic [BCNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [DCNT_W-1:0]     dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [3:0]            top_digit;
  logic                  out_free;

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd_r[4*i +: 4] >= BCD_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + BCD_ADJUST;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.load) begin
      neg_nxt     = in_value[VALUE_BITS-1];
      mag_nxt     = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bcd_nxt     = '0;
      bit_cnt_nxt = BCNT_W'(VALUE_BITS);
      dig_cnt_nxt = DCNT_W'(ND);
    end
    if (cmd.conv) begin
      {bcd_nxt, mag_nxt} = {bcd_adj[BCD_W-2:0], mag_r, 1'b0};
      bit_cnt_nxt        = bit_cnt_r - BCNT_W'(1);
    end
    if (cmd.skip || cmd.digit) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r - DCNT_W'(1);
    end
    if (cmd.sign) begin
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.digit) begin
      out_char_nxt  = CHAR_ZERO + {4'd0, top_digit};
      out_last_nxt  = (dig_cnt_r == DCNT_W'(1));
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.conv_last = (bit_cnt_r == BCNT_W'(1));
  assign sts.top_zero  = (top_digit == 4'd0);
  assign sts.cnt_one   = (dig_cnt_r == DCNT_W'(1));
  assign sts.neg       = neg_r;
  assign sts.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal ASCII converter.
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      tvalid / tready    tdata: value (VALUE_BITS, signed)
//   out_*     output     tvalid / tready    tdata: char_code (8); tlast: last_char
//
// One transaction on the input runs a load, the shift-and-add-3 BCD loop over all
// VALUE_BITS bits, a skip of leading zeros plus an exit step, a minus sign for a
// negative value and then the digits. Skipped zeros and digits always add up to
// ND, and the bit-serial BCD loop takes most of the time of an item.
// Reset is synchronous and active low; it clears the controller and output valid.
// A character waiting with out_tready low stalls the sign and digit steps; the next
// input transaction may be taken once the last character is registered.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] in_tdata,   // [VALUE_BITS-1:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] char_code
  output logic                                out_tlast
);
  import itoa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.conv, cmd.skip, cmd.sign, cmd.digit}))
    else $error("More than one datapath command at once.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Input ready while a conversion is in progress.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == CHAR_MINUS) |-> !out_tlast)
    else $error("Minus sign flagged as last character.");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CHAR_MINUS ||
                    (out_tdata >= CHAR_ZERO && out_tdata <= CHAR_ZERO + 8'd9)))
    else $error("Output character is neither a digit nor a minus sign.");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sign || cmd.digit) |-> (!out_tvalid || out_tready))
    else $error("Character loaded over a pending output transaction.");

endmodule

// ===== tb/itoa_checker.sv =====
// Checker that predicts the decimal text of each input transaction and compares the output.
module itoa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_chars
);
  import itoa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];
  int         mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic void predict_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digits[$];
    text_char_t  c;
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      digits.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (value[31]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.code = CHAR_ZERO + {4'd0, digits[i]};
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character transaction: char_code %0d last_char %0b",
                 out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.code) begin
            $error("char_code mismatch: expected %0d, actual %0d", want.code, out_tdata);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("last_char mismatch: expected %0b, actual %0b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending_chars <= expected_chars.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top that drives the decimal ASCII converter and reports the verdict.
module tb;
  import itoa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_chars;

  bit tx_idle_en;
  bit rx_idle_en;
  bit long_hold_req;

  signed_int_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS_DEF)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  itoa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_chars(pending_chars)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(15, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] pow10;
    int          k;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        pow10 = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) pow10 = pow10 * 32'd10;
        v = pow10 - $urandom_range(0, 1);
      end
      3: v = $urandom >> $urandom_range(0, 31);
      default: v = 32'h7fff_ffff - $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_gap();
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 -32'd999999999, 32'd123456789, -32'd5, 32'd4000, -32'd1000000000,
                 32'h5555_5555, 32'haaaa_aaaa, 32'd2147483640};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_value(directed[i]);
    end
    drain();

    long_hold_req = 1'b1;
    repeat (30) begin
      send_value(pick_value());
    end
    drain();

    repeat (40) begin
      send_value(pick_value());
    end

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (80) begin
      send_value(pick_value());
      send_gap();
    end
    drain();

    repeat (80) begin
      send_value(pick_value());
      send_gap();
    end

    drain();
    if (fail_count == 0 && pending_chars == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dp.sv
hw/rtl/signed_int_to_decimal_ascii_top.sv
tb/itoa_checker.sv
tb/tb.sv
